FILE: hw/rtl/stbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned DATA_W      = 32;

  // Operation codes carried in op
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Search sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

FILE: hw/rtl/sorted_table_binary_search.sv
// Sorted table binary search.
// Input channel (in_valid_i / in_stall_o) carries one word: op selects a table
// write (write_index_i, write_value_i) or a search (search_key_i). A write is
// stored in the cycle it is accepted and gives no result. A search runs the
// classic binary search over entries 0 to entry_count-1 and gives one result
// word (found_o, match_index_o) on the output channel (out_valid_o /
// out_stall_i); match_index_o is 0 when the key is absent.
// In each probe the PROBE state reads the table memory and the CMP state then
// compares and moves a bound. The block takes no new word while a search runs;
// after a write it is ready for the next word. entry_count is set through
// cfg_we_i / cfg_data_i; the user must do so only while the block is idle, as
// the block itself does not enforce it. Values above the table depth are
// treated as the depth. Reset clears the sequencer, the output valid and
// entry_count; table contents stay undefined until written. A finished result
// waits in the output register while the receiver stalls; further writes are
// still accepted, and a later search holds in its last state until the result
// register is free.
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_binary_search
  import stbs_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CNT_W-1:0]         cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic                     op_i,
  input  wire logic [IDX_W-1:0]         write_index_i,
  input  wire logic signed [DATA_W-1:0] write_value_i,
  input  wire logic signed [DATA_W-1:0] search_key_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic                          found_o,
  output logic [IDX_W-1:0]              match_index_o
);

  state_e state_q, state_d;

  logic [CNT_W-1:0]         entry_count_q;
  logic [CNT_W-1:0]         lo_q, lo_d, hi_q, hi_d;
  logic [IDX_W-1:0]         mid_q, mid_d;
  logic signed [DATA_W-1:0] key_q, key_d;
  logic                     res_found_q, res_found_d;
  logic [IDX_W-1:0]         res_idx_q, res_idx_d;
  logic                     out_valid_q, out_valid_d;
  logic                     found_q;
  logic [IDX_W-1:0]         match_index_q;

  logic signed [DATA_W-1:0] table_mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] rd_data_q;

  logic             in_acc;
  logic             mem_we;
  logic             mem_re;
  logic             out_free;
  logic             out_load;
  logic [CNT_W-1:0] count_sat;
  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid_full;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Clamp the entry count to the table depth
  assign count_sat = (entry_count_q > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                           : entry_count_q;

  // Midpoint of the inclusive bounds [lo, hi-1], rounded down
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q} - (CNT_W + 1)'(1);
  assign mid_full = mid_sum[CNT_W:1];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (op_i == OP_SEARCH)) begin
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (lo_q < hi_q) begin
          state_d = ST_CMP;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CMP: begin
        if (rd_data_q == key_q) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_PROBE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    in_stall_o  = 1'b1;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    out_load    = 1'b0;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    key_d       = key_q;
    res_found_d = res_found_q;
    res_idx_d   = res_idx_q;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (op_i == OP_WRITE) begin
            mem_we = 1'b1;
          end else begin
            lo_d        = '0;
            hi_d        = count_sat;
            key_d       = search_key_i;
            res_found_d = 1'b0;
            res_idx_d   = '0;
          end
        end
      end
      ST_PROBE: begin
        if (lo_q < hi_q) begin
          mem_re = 1'b1;
          mid_d  = mid_full[IDX_W-1:0];
        end
      end
      ST_CMP: begin
        if (rd_data_q > key_q) begin
          hi_d = {1'b0, mid_q};
        end else if (rd_data_q < key_q) begin
          lo_d = {1'b0, mid_q} + CNT_W'(1);
        end else begin
          res_found_d = 1'b1;
          res_idx_d   = mid_q;
        end
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Output register: load a finished result, drop valid once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      entry_count_q <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        entry_count_q <= cfg_data_i;
      end
    end
  end

  // Search datapath registers
  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    key_q       <= key_d;
    res_found_q <= res_found_d;
    res_idx_q   <= res_idx_d;
    if (out_load) begin
      found_q       <= res_found_q;
      match_index_q <= res_idx_q;
    end
  end

  // Table memory: one write port, one registered read port. Writes happen
  // only while idle and reads only while searching, so they never overlap.
  always_ff @(posedge clk_i) begin
    if (mem_we && in_acc) begin
      table_mem[write_index_i] <= write_value_i;
    end
    if (mem_re) begin
      rd_data_q <= table_mem[mid_full[IDX_W-1:0]];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign match_index_o = match_index_q;

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_table_binary_search_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_binary_search_chk
  import stbs_pkg::*;
(
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_stall_o,
  input wire logic                     op_i,
  input wire logic                     out_valid_o,
  input wire logic                     out_stall_i,
  input wire logic                     found_o,
  input wire logic [IDX_W-1:0]         match_index_o
);

  // Hold a stalled result word
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(found_o) && $stable(match_index_o))
    else $error("result word changed while stalled");

  // A miss reports index zero
  a_miss_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> match_index_o == '0)
    else $error("miss with nonzero index");

  // A search occupies the block; a write leaves it ready
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (op_i == OP_SEARCH) |=> in_stall_o)
    else $error("input taken during a search");

  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (op_i == OP_WRITE) |=> !in_stall_o)
    else $error("stall after a table write");

endmodule

bind sorted_table_binary_search sorted_table_binary_search_chk u_chk (.*);

`default_nettype wire
